// ----- hw/rtl/fbd_pkg.sv -----
// Shared types and constants for the framebuffer difference run detector.
// Holds the configuration bundle, the segment word and the result buffer sizing.
// No dependencies.
package fbd_pkg;

    localparam int SEG_COORD_W = 10;
    localparam int SEG_BUF_DEPTH = 4;
    localparam int SEG_BUF_PTR_W = 2;
    localparam int SEG_BUF_CNT_W = 3;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_WHITE_LEVEL  = 2'd2
    } reg_index_t;

    typedef enum logic {
        KIND_CHANGED  = 1'b0,
        KIND_WHITENED = 1'b1
    } region_kind_t;

    typedef struct packed {
        logic [10:0] frame_width;
        logic [10:0] frame_height;
        logic [7:0]  white_level;
    } cfg_t;

    typedef struct packed {
        region_kind_t           region_kind;
        logic [SEG_COORD_W-1:0] row_index;
        logic [SEG_COORD_W-1:0] start_col;
        logic [SEG_COORD_W-1:0] end_col;
        logic                   last_of_run;
    } seg_t;

    typedef struct packed {
        logic [1:0] count;
        seg_t       first;
        seg_t       second;
    } seg_pair_t;

endpackage

// ----- hw/rtl/fbd_tracker.sv -----
// Raster position counters and the two open-run trackers of the detector.
// Produces up to two segments for the pixel pair held in the input register.
// Depends on fbd_pkg.
module fbd_tracker
    import fbd_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      step,
    input  logic [7:0] old_pixel,
    input  logic [7:0] new_pixel,
    output seg_pair_t segs
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int DCW = (CW + 1 > 11) ? CW + 1 : 11;
    localparam int DRW = (RW + 1 > 11) ? RW + 1 : 11;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          ch_open_reg, ch_open_next;
    logic [CW-1:0] ch_begin_reg, ch_begin_next;
    logic          wh_open_reg, wh_open_next;
    logic [CW-1:0] wh_begin_reg, wh_begin_next;

    logic [DCW-1:0] fw_ext;
    logic [DRW-1:0] fh_ext;
    logic [CW-1:0]  w_last;
    logic [RW-1:0]  h_last;
    logic           row_end;
    logic           changed;
    logic           whitened;
    logic           ch_emit;
    logic           wh_emit;
    seg_t           ch_seg;
    seg_t           wh_seg;

    always_comb
    begin
        fw_ext = DCW'(cfg.frame_width);
        fh_ext = DRW'(cfg.frame_height);
        if (fw_ext == '0)
        begin
            w_last = '0;
        end
        else if (fw_ext > DCW'(MAX_COLS))
        begin
            w_last = CW'(MAX_COLS - 1);
        end
        else
        begin
            w_last = CW'(fw_ext - DCW'(1));
        end
        if (fh_ext == '0)
        begin
            h_last = '0;
        end
        else if (fh_ext > DRW'(MAX_ROWS))
        begin
            h_last = RW'(MAX_ROWS - 1);
        end
        else
        begin
            h_last = RW'(fh_ext - DRW'(1));
        end
    end

    always_comb
    begin
        row_end  = (col_reg >= w_last);
        changed  = (old_pixel != new_pixel);
        whitened = (old_pixel != cfg.white_level) && (new_pixel == cfg.white_level);

        // A run closes on the first pixel outside it, or on the last pixel of the row.
        ch_emit = (!changed && ch_open_reg) || (changed && row_end);
        wh_emit = (!whitened && wh_open_reg) || (whitened && row_end);

        ch_seg.region_kind = KIND_CHANGED;
        ch_seg.row_index   = SEG_COORD_W'(row_reg);
        ch_seg.start_col   = ch_open_reg ? SEG_COORD_W'(ch_begin_reg) : SEG_COORD_W'(col_reg);
        ch_seg.end_col     = changed ? SEG_COORD_W'(col_reg)
                                     : SEG_COORD_W'(col_reg - CW'(1));
        ch_seg.last_of_run = !wh_emit;

        wh_seg.region_kind = KIND_WHITENED;
        wh_seg.row_index   = SEG_COORD_W'(row_reg);
        wh_seg.start_col   = wh_open_reg ? SEG_COORD_W'(wh_begin_reg) : SEG_COORD_W'(col_reg);
        wh_seg.end_col     = whitened ? SEG_COORD_W'(col_reg)
                                      : SEG_COORD_W'(col_reg - CW'(1));
        wh_seg.last_of_run = 1'b1;

        segs.count  = {1'b0, ch_emit} + {1'b0, wh_emit};
        segs.first  = ch_emit ? ch_seg : wh_seg;
        segs.second = wh_seg;
    end

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        ch_open_next  = ch_open_reg;
        ch_begin_next = ch_begin_reg;
        wh_open_next  = wh_open_reg;
        wh_begin_next = wh_begin_reg;
        if (step)
        begin
            ch_open_next = changed && !row_end;
            wh_open_next = whitened && !row_end;
            if (!ch_open_reg)
            begin
                ch_begin_next = col_reg;
            end
            if (!wh_open_reg)
            begin
                wh_begin_next = col_reg;
            end
            if (row_end)
            begin
                col_next = '0;
                row_next = (row_reg >= h_last) ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            ch_open_reg  <= 1'b0;
            ch_begin_reg <= '0;
            wh_open_reg  <= 1'b0;
            wh_begin_reg <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            ch_open_reg  <= ch_open_next;
            ch_begin_reg <= ch_begin_next;
            wh_open_reg  <= wh_open_next;
            wh_begin_reg <= wh_begin_next;
        end
    end

endmodule

// ----- hw/rtl/fbd_seg_buffer.sv -----
// Small result buffer for segments: takes up to two words per cycle, gives one.
// Its registers form the output stage of the detector.
// Depends on fbd_pkg.
module fbd_seg_buffer
    import fbd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  seg_pair_t segs,
    output logic      room2,
    output logic      out_valid,
    input  logic      out_ready,
    output seg_t      out_seg
);

    seg_t                     entry_reg [SEG_BUF_DEPTH];
    logic [SEG_BUF_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [SEG_BUF_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [SEG_BUF_CNT_W-1:0] count_reg, count_next;
    logic [1:0]               n_push;
    logic                     pop;

    assign n_push    = push ? segs.count : 2'd0;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign room2     = (count_reg <= SEG_BUF_CNT_W'(SEG_BUF_DEPTH - 2));
    assign out_seg   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + SEG_BUF_PTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + SEG_BUF_PTR_W'(pop);
        count_next  = count_reg + SEG_BUF_CNT_W'(n_push) - SEG_BUF_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= segs.first;
        end
        if (n_push == 2'd2)
        begin
            entry_reg[wr_ptr_reg + SEG_BUF_PTR_W'(1)] <= segs.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hw/rtl/framebuffer_diff_run_detector.sv -----
// Top level of the framebuffer difference run detector.
// Holds the configuration registers and the input register; uses fbd_tracker,
// fbd_seg_buffer and fbd_pkg.
//
//   channel  | signals                                  | word
//   ---------+------------------------------------------+--------------------------------
//   s (in)   | s_tvalid s_tready s_tdata                 | old_pixel, new_pixel
//   m (out)  | m_tvalid m_tready m_tdata m_tuser m_tlast | row, start, end; kind; last
//   cfg      | cfg_valid cfg_ready cfg_index cfg_data   | register index, value
//
// One pixel pair is taken per cycle; its segments reach the output through the buffer
// registers. A pair leaves the input register only when the four-entry result buffer
// has room for two segments, so the input stalls only while results back up.
// Reset clears the counters, the trackers and the buffer and loads the default
// frame size and white level. Configuration writes are taken in every cycle.
module framebuffer_diff_run_detector
    import fbd_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // old_pixel [7:0], new_pixel [15:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // row_index [9:0], start_col [19:10], end_col [29:20]
    output logic [0:0]  m_tuser,   // region_kind [0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    cfg_t       cfg_reg, cfg_next;
    logic       pix_vld_reg, pix_vld_next;
    logic [7:0] old_reg;
    logic [7:0] new_reg;
    logic       step;
    logic       room2;
    seg_pair_t  segs;
    seg_t       out_seg;

    assign cfg_ready = 1'b1;
    assign step      = pix_vld_reg && room2;
    assign s_tready  = !pix_vld_reg || step;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  cfg_next.frame_width  = cfg_data;
                REG_FRAME_HEIGHT: cfg_next.frame_height = cfg_data;
                REG_WHITE_LEVEL:  cfg_next.white_level  = cfg_data[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
        pix_vld_next = s_tready ? s_tvalid : pix_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= 11'd600;
            cfg_reg.frame_height <= 11'd800;
            cfg_reg.white_level  <= 8'd255;
            pix_vld_reg          <= 1'b0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            pix_vld_reg <= pix_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            old_reg <= s_tdata[7:0];
            new_reg <= s_tdata[15:8];
        end
    end

    fbd_tracker #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .step      (step),
        .old_pixel (old_reg),
        .new_pixel (new_reg),
        .segs      (segs)
    );

    fbd_seg_buffer u_seg_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .segs      (segs),
        .room2     (room2),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_seg   (out_seg)
    );

    assign m_tdata = {2'b00, out_seg.end_col, out_seg.start_col, out_seg.row_index};
    assign m_tuser = out_seg.region_kind;
    assign m_tlast = out_seg.last_of_run;

endmodule

// ----- hw/rtl/fbd_port_checker.sv -----
// Port-level checks for the framebuffer difference run detector.
// Bound to the top level; depends only on its ports.
// No package dependencies.
module fbd_port_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled output word holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
    else $error("output word changed while stalled");

    // A dark-to-white segment is always the final one for its pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast)
    else $error("dark-to-white segment without last flag");

    // A changed segment that is not last is followed at once by a dark-to-white
    // segment of the same row.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser[0]
            && (m_tdata[9:0] == $past(m_tdata[9:0])))
    else $error("missing dark-to-white partner segment");

    // The input stalls only while results are waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
    else $error("input stalled with empty output");

endmodule

bind framebuffer_diff_run_detector fbd_port_checker u_port_checker (.*);

// ----- test/framebuffer_diff_run_detector_tb.sv -----
// Self-checking testbench for framebuffer_diff_run_detector: drives pixel pairs and register
// writes, predicts every segment word and compares each one as it leaves the block.
// Depends on fbd_pkg and the framebuffer_diff_run_detector RTL.
module framebuffer_diff_run_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fbd_pkg::*;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;

    typedef enum int
    {
        RUN_SAME,
        RUN_CHANGE,
        RUN_WHITEN,
        RUN_WHITE,
        RUN_NOISE
    } pixel_run_t;

    class segment_scoreboard;
        int          max_cols;
        int          max_rows;
        logic [10:0] frame_width;
        logic [10:0] frame_height;
        logic [7:0]  white_level;
        bit   [9:0]  col_pos;
        bit   [9:0]  row_pos;
        bit          change_open;
        bit   [9:0]  change_first;
        bit          whiten_open;
        bit   [9:0]  whiten_first;
        seg_t        expected_segs[$];
        int          mismatches;

        function new(int cols, int rows);
            max_cols = cols;
            max_rows = rows;
            frame_width = 11'd600;
            frame_height = 11'd800;
            white_level = 8'd255;
            col_pos = '0;
            row_pos = '0;
            change_open = 1'b0;
            change_first = '0;
            whiten_open = 1'b0;
            whiten_first = '0;
            mismatches = 0;
        endfunction

        function void write_register(reg_index_t idx, logic [10:0] value);
            case (idx)
                REG_FRAME_WIDTH:  frame_width = value;
                REG_FRAME_HEIGHT: frame_height = value;
                REG_WHITE_LEVEL:  white_level = value[7:0];
                default:          ;
            endcase
        endfunction

        function int pending();
            return expected_segs.size();
        endfunction

        function seg_t make_seg(region_kind_t kind, bit [9:0] first_col, bit [9:0] last_col);
            seg_t s;
            s.region_kind = kind;
            s.row_index = row_pos;
            s.start_col = first_col;
            s.end_col = last_col;
            s.last_of_run = 1'b0;
            return s;
        endfunction

        function void note_pixel(logic [7:0] old_px, logic [7:0] new_px);
            seg_t segs[2];
            int   n;
            int   w;
            int   h;
            bit   row_end;
            bit   changed;
            bit   whitened;
            w = (frame_width == 0) ? 1 : ((int'(frame_width) > max_cols) ? max_cols
                                                                         : int'(frame_width));
            h = (frame_height == 0) ? 1 : ((int'(frame_height) > max_rows) ? max_rows
                                                                           : int'(frame_height));
            row_end = int'(col_pos) >= w - 1;
            changed = old_px != new_px;
            whitened = (old_px != white_level) && (new_px == white_level);
            n = 0;

            if (changed)
            begin
                if (!change_open)
                begin
                    change_open = 1'b1;
                    change_first = col_pos;
                end
            end
            else if (change_open)
            begin
                segs[n] = make_seg(KIND_CHANGED, change_first, col_pos - 10'd1);
                n++;
                change_open = 1'b0;
            end
            if (row_end && change_open)
            begin
                segs[n] = make_seg(KIND_CHANGED, change_first, col_pos);
                n++;
                change_open = 1'b0;
            end

            if (whitened)
            begin
                if (!whiten_open)
                begin
                    whiten_open = 1'b1;
                    whiten_first = col_pos;
                end
            end
            else if (whiten_open)
            begin
                segs[n] = make_seg(KIND_WHITENED, whiten_first, col_pos - 10'd1);
                n++;
                whiten_open = 1'b0;
            end
            if (row_end && whiten_open)
            begin
                segs[n] = make_seg(KIND_WHITENED, whiten_first, col_pos);
                n++;
                whiten_open = 1'b0;
            end

            for (int i = 0; i < n; i++)
            begin
                segs[i].last_of_run = (i == n - 1);
                expected_segs.push_back(segs[i]);
            end

            if (row_end)
            begin
                col_pos = '0;
                row_pos = (int'(row_pos) >= h - 1) ? 10'd0 : row_pos + 10'd1;
            end
            else
            begin
                col_pos = col_pos + 10'd1;
            end
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_segment(seg_t got);
            seg_t want;
            if (expected_segs.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word kind %0d row %0d cols %0d..%0d last %0d",
                                          got.region_kind, got.row_index, got.start_col,
                                          got.end_col, got.last_of_run));
                return;
            end
            want = expected_segs.pop_front();
            if (got.region_kind !== want.region_kind || got.row_index !== want.row_index ||
                got.start_col !== want.start_col || got.end_col !== want.end_col ||
                got.last_of_run !== want.last_of_run)
            begin
                report_mismatch($sformatf(
                    "got kind %0d row %0d cols %0d..%0d last %0d, want %0d %0d %0d..%0d %0d",
                    got.region_kind, got.row_index, got.start_col, got.end_col, got.last_of_run,
                    want.region_kind, want.row_index, want.start_col, want.end_col,
                    want.last_of_run));
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_FRAME_WIDTH;
    logic [10:0] cfg_data = '0;

    segment_scoreboard sb;
    bit                in_quiet = 1'b0;
    bit                out_quiet = 1'b0;
    int                out_hold = 0;
    pixel_run_t        run_mode = RUN_SAME;

    framebuffer_diff_run_detector #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int gap_length();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    always @(posedge clk)
    begin
        if (out_hold > 0)
        begin
            m_tready <= 1'b0;
            out_hold <= out_hold - 1;
        end
        else if (out_quiet || $urandom_range(0, 99) < 70)
        begin
            m_tready <= 1'b1;
        end
        else
        begin
            m_tready <= 1'b0;
            out_hold <= gap_length() - 1;
        end
    end

    always @(posedge clk)
    begin : watch_output
        seg_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.region_kind = region_kind_t'(m_tuser[0]);
            got.row_index = m_tdata[9:0];
            got.start_col = m_tdata[19:10];
            got.end_col = m_tdata[29:20];
            got.last_of_run = m_tlast;
            sb.check_segment(got);
        end
    end

    task automatic configure(logic [10:0] width, logic [10:0] height, logic [7:0] white);
        logic [10:0] values[3];
        values[0] = width;
        values[1] = height;
        values[2] = {3'b000, white};
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_index_t'(i);
            cfg_data <= values[i];
            do @(posedge clk); while (!cfg_ready);
            sb.write_register(reg_index_t'(i), values[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Leaves tvalid high after the handshake so that a back-to-back word needs no second
    // assignment in the same step; a drain, or a next call that inserts a gap, lowers it.
    task automatic send_pixel(logic [7:0] old_px, logic [7:0] new_px);
        int gap;
        gap = (in_quiet || $urandom_range(0, 99) < 60) ? 0 : gap_length();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {new_px, old_px};
        do @(posedge clk); while (!s_tready);
        sb.note_pixel(old_px, new_px);
    endtask

    task automatic hold_until_drained(int settle);
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (settle) @(posedge clk);
    endtask

    function automatic void pick_pair(output logic [7:0] old_px, output logic [7:0] new_px);
        if ($urandom_range(0, 3) == 0)
            run_mode = pixel_run_t'($urandom_range(0, 4));
        old_px = 8'($urandom);
        case (run_mode)
            RUN_SAME:   new_px = old_px;
            RUN_CHANGE: new_px = old_px ^ 8'($urandom_range(1, 255));
            RUN_WHITEN:
            begin
                if (old_px == sb.white_level)
                    old_px = old_px ^ 8'h01;
                new_px = sb.white_level;
            end
            RUN_WHITE:
            begin
                old_px = sb.white_level;
                new_px = sb.white_level;
            end
            default:    new_px = 8'($urandom);
        endcase
    endfunction

    task automatic run_phase(logic [10:0] width, logic [10:0] height, logic [7:0] white,
                             int count);
        logic [7:0] old_px;
        logic [7:0] new_px;
        hold_until_drained(6);
        configure(width, height, white);
        in_quiet = ($urandom_range(0, 3) == 0);
        out_quiet = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 199) == 0)
                hold_until_drained(0);
            pick_pair(old_px, new_px);
            send_pixel(old_px, new_px);
        end
    endtask

    function automatic logic [7:0] pick_white();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [10:0] pick_width();
        case ($urandom_range(0, 9))
            0:       return 11'd0;
            1:       return 11'd1;
            2:       return 11'd2047;
            3:       return 11'd1024;
            4:       return 11'($urandom_range(13, 40));
            default: return 11'($urandom_range(2, 12));
        endcase
    endfunction

    function automatic logic [10:0] pick_height();
        case ($urandom_range(0, 9))
            0:       return 11'd0;
            1:       return 11'd2047;
            default: return 11'($urandom_range(1, 5));
        endcase
    endfunction

    initial
    begin : stimulus
        sb = new(MAX_COLS, MAX_ROWS);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Both trackers open and close together, and runs still open at the end of a row.
        configure(11'd6, 11'd2, 8'd200);
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd10, 8'd200);
        send_pixel(8'd200, 8'd200);
        send_pixel(8'd0, 8'd255);
        send_pixel(8'd255, 8'd0);
        send_pixel(8'd1, 8'd200);
        send_pixel(8'd255, 8'd200);
        send_pixel(8'd200, 8'd200);
        send_pixel(8'd255, 8'd255);
        send_pixel(8'd0, 8'd0);

        // The row is cut short when the width shrinks below the current column.
        hold_until_drained(6);
        configure(11'd16, 11'd4, 8'd0);
        send_pixel(8'd9, 8'd0);
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd5, 8'd6);
        send_pixel(8'd7, 8'd0);
        send_pixel(8'd1, 8'd2);
        hold_until_drained(6);
        configure(11'd3, 11'd4, 8'd0);
        send_pixel(8'd3, 8'd4);
        send_pixel(8'd0, 8'd0);

        // The row counter wraps early when the height shrinks below the current row.
        hold_until_drained(6);
        configure(11'd2, 11'd6, 8'd255);
        send_pixel(8'd0, 8'd255);
        send_pixel(8'd255, 8'd255);
        send_pixel(8'd4, 8'd4);
        send_pixel(8'd0, 8'd1);
        send_pixel(8'd1, 8'd1);
        send_pixel(8'd7, 8'd255);
        hold_until_drained(6);
        configure(11'd2, 11'd1, 8'd255);
        send_pixel(8'd0, 8'd255);
        send_pixel(8'd255, 8'd0);

        // Zero width acts as one column, so every pixel ends its row.
        run_phase(11'd0, 11'd2047, pick_white(), 40);
        // An oversized width saturates to the largest row.
        run_phase(11'd2047, 11'd1, 8'd255, 40);
        for (int p = 0; p < 10; p++)
            run_phase(pick_width(), pick_height(), pick_white(), 80);

        hold_until_drained(10);
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #40ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
